// ----- rtl/qpd_pkg.sv -----
// Package for the quoted-printable decoder: phase codes, result word and state types,
// character constants and the hex digit and line-break functions. No dependencies.
`default_nettype none
package qpd_pkg;

  typedef enum logic [1:0] {
    PH_PLAIN = 2'd0,
    PH_ESC   = 2'd1,
    PH_HIGH  = 2'd2,
    PH_SOFT  = 2'd3
  } phase_e;

  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  typedef struct packed {
    logic       has;
    logic [7:0] data;
    logic       valid;
    logic       last;
  } res_t;

  typedef struct packed {
    phase_e     phase;
    logic [3:0] high;
  } state_t;

  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) v = c[3:0];
    else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
      v = 4'(c[2:0] + 3'd1) + 4'd8;
    return v;
  endfunction

  function automatic logic is_break(input logic [7:0] c);
    return (c == CH_CR) || (c == CH_LF);
  endfunction

endpackage
`default_nettype wire

// ----- rtl/quoted_printable_decoder.sv -----
// Quoted-printable decoder top level: mode register, phase state, output and skid words.
// Depends on qpd_pkg and qpd_step.
// A result word is registered in the output word, or in the skid word on a stall.
// Throughput: 1 byte per cycle while in_stall_o is low; qpd_step is combinational.
// A skid word keeps input flowing while a result waits on the output, until it fills.
// Reset (async, active low): plain-text phase, body mode, both output words empty.
`default_nettype none
module quoted_printable_decoder import qpd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  output logic       res_valid_o,
  input  logic       res_stall_i,
  output logic [7:0] out_byte_o,
  output logic       out_valid_o,
  output logic       out_last_o
);

  logic   mode_q;
  state_t st_q, st_d;
  res_t   step_res;
  res_t   out_q, skid_q;
  logic   res_valid_q, skid_valid_q;
  logic   in_fire, out_free;

  assign in_stall_o = skid_valid_q;
  assign in_fire    = in_valid_i && !skid_valid_q;
  assign out_free   = !res_valid_q || !res_stall_i;

  qpd_step u_step (
    .state_i (st_q),
    .mode_i  (mode_q),
    .byte_i  (in_byte_i),
    .last_i  (in_last_i),
    .state_o (st_d),
    .res_o   (step_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= 1'b0;
      st_q     <= '{phase: PH_PLAIN, high: 4'd0};
    end else begin
      if (cfg_we_i) mode_q <= cfg_wdata_i;
      if (in_fire)  st_q   <= st_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      res_valid_q  <= skid_valid_q || (in_fire && step_res.has);
      skid_valid_q <= 1'b0;
    end else if (in_fire && step_res.has) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= skid_valid_q ? skid_q : step_res;
    end else if (in_fire && step_res.has) begin
      skid_q <= step_res;
    end
  end

  assign res_valid_o = res_valid_q;
  assign out_byte_o  = out_q.data;
  assign out_valid_o = out_q.valid;
  assign out_last_o  = out_q.last;

  a_skid_implies_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> res_valid_q) else $error("skid word held with empty output");

  a_last_resets_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_last_i) |=> (st_q.phase == PH_PLAIN))
    else $error("phase not plain after last byte");

  a_word_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> (out_q.valid || out_q.last)) else $error("empty result word");

  a_idle_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && !out_q.valid) |-> (out_q.data == 8'd0))
    else $error("byte nonzero on result without data");

endmodule
`default_nettype wire

// ----- rtl/qpd_step.sv -----
// Per-byte decode step: next phase and pending digit, plus the result word.
// Purely combinational; depends on qpd_pkg.
`default_nettype none
module qpd_step import qpd_pkg::*; (
  input  state_t     state_i,
  input  logic       mode_i,
  input  logic [7:0] byte_i,
  input  logic       last_i,
  output state_t     state_o,
  output res_t       res_o
);

  logic       valid;
  logic [7:0] ob;
  phase_e     eff;
  logic       swallow;

  always_comb begin
    state_o = state_i;
    valid   = 1'b0;
    ob      = 8'd0;
    swallow = (state_i.phase == PH_SOFT) && is_break(byte_i);
    eff     = (state_i.phase == PH_SOFT) ? PH_PLAIN : state_i.phase;

    if (swallow) begin
      state_o.phase = PH_PLAIN;
    end else begin
      case (eff)
        PH_PLAIN: begin
          if (byte_i == CH_EQ) begin
            state_o.phase = PH_ESC;
          end else begin
            ob    = (mode_i && byte_i == CH_UNDER) ? CH_SPACE : byte_i;
            valid = 1'b1;
            state_o.phase = PH_PLAIN;
          end
        end
        PH_ESC: begin
          if (!mode_i && is_break(byte_i)) begin
            state_o.phase = PH_SOFT;
          end else begin
            state_o.high  = hex_value(byte_i);
            state_o.phase = PH_HIGH;
          end
        end
        PH_HIGH: begin
          ob    = {state_i.high, hex_value(byte_i)};
          valid = 1'b1;
          state_o.phase = PH_PLAIN;
        end
        default: begin
          state_o.phase = PH_PLAIN;
        end
      endcase
    end

    if (last_i) state_o.phase = PH_PLAIN;

    res_o.has   = valid | last_i;
    res_o.data  = ob;
    res_o.valid = valid;
    res_o.last  = last_i;
  end

endmodule
`default_nettype wire

// ----- bench/quoted_printable_decoder_test.sv -----
`timescale 1ns / 1ps
// Self-checking bench for quoted_printable_decoder: directed and random byte streams in
// body and header modes under source idling and result stalls. Depends on qpd_pkg and the DUT.
module quoted_printable_decoder_test import qpd_pkg::*; ();

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 4;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       last;
  } decoded_t;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       cfg_we_i    = 1'b0;
  logic       cfg_wdata_i = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic [7:0] in_byte_i   = 8'h00;
  logic       in_last_i   = 1'b0;
  logic       res_stall_i = 1'b0;
  logic       in_stall_o;
  logic       res_valid_o;
  logic [7:0] out_byte_o;
  logic       out_valid_o;
  logic       out_last_o;

  decoded_t   decoded_q[$];
  decoded_t   oldest;
  int         failures      = 0;
  int         words_sent    = 0;
  int         idle_cycles   = 0;
  int         src_idle_pct  = 0;
  int         snk_stall_pct = 0;

  // predictor state
  phase_e     qp_phase  = PH_PLAIN;
  logic [3:0] qp_high   = 4'd0;
  logic       qp_header = 1'b0;

  quoted_printable_decoder DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_byte_i   (in_byte_i),
    .in_last_i   (in_last_i),
    .res_valid_o (res_valid_o),
    .res_stall_i (res_stall_i),
    .out_byte_o  (out_byte_o),
    .out_valid_o (out_valid_o),
    .out_last_o  (out_last_o)
  );

  always #5 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    res_stall_i <= ($urandom_range(99) < snk_stall_pct);
  end

  function automatic logic [3:0] nibble_of(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return 4'(c - 8'h30);
    if (c >= 8'h41 && c <= 8'h46) return 4'(c - 8'h37);
    if (c >= 8'h61 && c <= 8'h66) return 4'(c - 8'h57);
    return 4'd0;
  endfunction

  task automatic predict_decode(input logic [7:0] c, input logic l);
    decoded_t w;
    logic     swallow;
    logic     brk;
    w       = '0;
    swallow = 1'b0;
    brk     = (c == CH_CR) || (c == CH_LF);
    if (qp_phase == PH_SOFT) begin
      if (brk) swallow = 1'b1;
      else qp_phase = PH_PLAIN;
    end
    if (swallow) begin
      qp_phase = PH_PLAIN;
    end else begin
      case (qp_phase)
        PH_PLAIN: begin
          if (c == CH_EQ) begin
            qp_phase = PH_ESC;
          end else begin
            w.data  = (qp_header && c == CH_UNDER) ? CH_SPACE : c;
            w.valid = 1'b1;
          end
        end
        PH_ESC: begin
          if (!qp_header && brk) begin
            qp_phase = PH_SOFT;
          end else begin
            qp_high  = nibble_of(c);
            qp_phase = PH_HIGH;
          end
        end
        default: begin
          w.data   = {qp_high, nibble_of(c)};
          w.valid  = 1'b1;
          qp_phase = PH_PLAIN;
        end
      endcase
    end
    if (l) qp_phase = PH_PLAIN;
    w.last = l;
    if (w.valid || l) decoded_q.push_back(w);
  endtask

  // called at a falling edge; returns at the falling edge after acceptance, valid left high
  task automatic send_word(input logic [7:0] b, input logic l);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    in_last_i  <= l;
    do @(posedge clk_i); while (in_stall_o);
    predict_decode(b, l);
    words_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (decoded_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_mode(input logic m);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= m;
    @(negedge clk_i);
    cfg_we_i  <= 1'b0;
    qp_header = m;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o && !res_stall_i) begin
      if (decoded_q.size() == 0) begin
        $error("unexpected word: byte %h valid %b last %b", out_byte_o, out_valid_o,
               out_last_o);
        failures++;
      end else begin
        oldest = decoded_q.pop_front();
        if (out_byte_o !== oldest.data) begin
          $error("out_byte: expected %h, got %h", oldest.data, out_byte_o);
          failures++;
        end
        if (out_valid_o !== oldest.valid) begin
          $error("out_valid: expected %b, got %b", oldest.valid, out_valid_o);
          failures++;
        end
        if (out_last_o !== oldest.last) begin
          $error("out_last: expected %b, got %b", oldest.last, out_last_o);
          failures++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (res_valid_o && !res_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [7:0] random_hex_char();
    int n;
    n = $urandom_range(23);
    if (n < 10) return 8'(8'h30 + n);
    if (n < 16) return 8'(8'h41 + n - 10);
    if (n < 22) return 8'(8'h61 + n - 16);
    return 8'($urandom_range(255));
  endfunction

  function automatic logic random_last();
    return ($urandom_range(24) == 0);
  endfunction

  task automatic send_random_chunk();
    logic [7:0] b;
    int         kind;
    kind = $urandom_range(9);
    case (kind)
      0, 1, 2, 3: begin
        b = 8'($urandom_range(255));
        if (b == CH_EQ) b = CH_UNDER;
        send_word(b, random_last());
      end
      4: send_word(CH_UNDER, random_last());
      5, 6: begin
        send_word(CH_EQ, random_last());
        send_word(random_hex_char(), random_last());
        send_word(random_hex_char(), random_last());
      end
      7: begin
        send_word(CH_EQ, random_last());
        send_word($urandom_range(1) ? CH_CR : CH_LF, random_last());
        if ($urandom_range(1)) send_word($urandom_range(1) ? CH_CR : CH_LF, random_last());
      end
      8: send_word(8'($urandom_range(255)), random_last());
      default: send_word(8'($urandom_range(255)), 1'b1);
    endcase
  endtask

  task automatic test_body_directed();
    write_mode(1'b0);
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(CH_UNDER, 1'b0);
    send_word(CH_EQ, 1'b0); send_word(8'h34, 1'b0); send_word(8'h61, 1'b0);
    send_word(CH_EQ, 1'b0); send_word(8'h46, 1'b0); send_word(8'h66, 1'b0);
    send_word(CH_EQ, 1'b0); send_word(8'h7A, 1'b0); send_word(8'h39, 1'b0);
    send_word(CH_EQ, 1'b0); send_word(CH_CR, 1'b0); send_word(CH_LF, 1'b0);
    send_word(CH_EQ, 1'b0); send_word(CH_LF, 1'b0); send_word(8'h58, 1'b0);
    send_word(CH_EQ, 1'b0); send_word(8'h33, 1'b1);
    send_word(CH_EQ, 1'b0); send_word(CH_CR, 1'b0); send_word(8'h41, 1'b1);
  endtask

  task automatic test_header_directed();
    write_mode(1'b1);
    send_word(CH_UNDER, 1'b0);
    send_word(CH_EQ, 1'b0); send_word(CH_CR, 1'b0); send_word(8'h67, 1'b0);
    send_word(CH_EQ, 1'b1);
  endtask

  // soft break pending across a switch to header mode still eats one line end
  task automatic test_mode_switch();
    write_mode(1'b0);
    send_word(CH_EQ, 1'b0);
    send_word(CH_CR, 1'b0);
    write_mode(1'b1);
    send_word(CH_LF, 1'b0);
    send_word(CH_UNDER, 1'b1);
  endtask

  task automatic test_random(input int src_pct, input int snk_pct, input int count);
    int target;
    src_idle_pct  = src_pct;
    snk_stall_pct = snk_pct;
    target = words_sent + count / 2;
    write_mode(1'b0);
    while (words_sent < target) send_random_chunk();
    target = words_sent + count / 2;
    write_mode(1'b1);
    while (words_sent < target) send_random_chunk();
    drain_results();
    src_idle_pct  = 0;
    snk_stall_pct = 0;
  endtask

  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_body_directed();
    test_header_directed();
    test_mode_switch();
    test_random(0, 0, 230);
    test_random(81, 0, 230);
    test_random(0, 81, 230);
    test_random(30, 30, 230);
    drain_results();
    if (failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
